FILE: sv/far_pkg.sv
// package for the fraction add and reduce block: widths, state type, command and status structs
`timescale 1ns / 1ps
package far_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int SUM_NUM_W = 32;
    localparam int SUM_DEN_W = 31;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_GCD,
        ST_DIV,
        ST_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic mul;
        logic gcd_start;
        logic gcd_step;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic gcd_done;
        logic div_done;
    } t_sts;

endpackage

FILE: sv/fraction_add_reduce.sv
// Adds two fractions a and b and reduces the sum by the gcd. One item at a time:
// the block takes no new item until the last result has been taken, and each item runs
// through the cross multiply, the one-step binary gcd loop and the bit-serial dividers.
// Invalid operands pass a through, an empty operand gives 0/0 with the flag set.
`timescale 1ns / 1ps
module fraction_add_reduce
    import far_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // a_num, a_den, b_num, b_den from bit 0 up
    input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // sum_num, sum_den, empty_flag from bit 0 up
    output logic [63:0]                         m_axis_tdata
);

    t_cmd cmd;
    t_sts sts;
    logic [SUM_NUM_W-1:0] sum_num;
    logic [SUM_DEN_W-1:0] sum_den;
    logic                 empty_flag;

    far_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    far_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_operands   (s_axis_tdata[4*OPERAND_WIDTH-1:0]),
        .o_sts        (sts),
        .o_sum_num    (sum_num),
        .o_sum_den    (sum_den),
        .o_empty_flag (empty_flag)
    );

    // pack the result transfer
    assign m_axis_tdata = {empty_flag, sum_den, sum_num};

endmodule

FILE: sv/far_datapath.sv
// datapath: operand checks, cross multiply, binary gcd and restoring division
`timescale 1ns / 1ps
module far_datapath
    import far_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    input  logic [4*OPERAND_WIDTH-1:0]  i_operands,
    output t_sts                        o_sts,
    output logic [SUM_NUM_W-1:0]        o_sum_num,
    output logic [SUM_DEN_W-1:0]        o_sum_den,
    output logic                        o_empty_flag
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W + 1;
    localparam int CW = $clog2(PW + 1);

    // result selection modes
    localparam logic [1:0] MODE_SUM   = 2'd0;
    localparam logic [1:0] MODE_EMPTY = 2'd1;
    localparam logic [1:0] MODE_PASS  = 2'd2;

    logic signed [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic [1:0]          r_mode;
    logic [PW-1:0]       r_n, r_d;
    logic [PW-1:0]       r_gx, r_gy;
    logic [CW-1:0]       r_gk;
    logic [PW-1:0]       r_q0, r_rem0, r_q1, r_rem1, r_g;
    logic [CW-1:0]       r_cnt;
    logic                r_div_busy;
    logic [SUM_NUM_W-1:0] r_sum_num;
    logic [SUM_DEN_W-1:0] r_sum_den;

    logic                n_valid, n_empty;
    logic [PW-1:0]       gx_sh, gy_sh, g_full;
    logic [PW:0]         tr0, tr1;
    logic [PW-1:0]       num_wide, den_wide;

    // operand classification
    always_comb begin
        n_valid = (r_an >= 0) && (r_ad > 0) && (r_bn >= 0) && (r_bd > 0);
        n_empty = ((r_an == 0) && (r_ad == 0)) || ((r_bn == 0) && (r_bd == 0));
    end

    // operand and product registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_an <= i_operands[W-1:0];
            r_ad <= i_operands[2*W-1:W];
            r_bn <= i_operands[3*W-1:2*W];
            r_bd <= i_operands[4*W-1:3*W];
        end
        if (i_cmd.mul) begin
            r_mode <= n_valid ? MODE_SUM : (n_empty ? MODE_EMPTY : MODE_PASS);
            r_n <= PW'($unsigned(r_an) * $unsigned(r_bd))
                 + PW'($unsigned(r_bn) * $unsigned(r_ad));
            r_d <= PW'($unsigned(r_ad) * $unsigned(r_bd));
        end
    end

    // binary gcd, one step a cycle; zero numerator gives divisor one
    always_comb begin
        gx_sh = r_gx >> 1;
        gy_sh = r_gy >> 1;
        g_full = r_gx << r_gk;
    end

    // a zero denominator only comes from unused operands, treat it as divisor one too
    always_ff @(posedge i_clk) begin
        if (i_cmd.gcd_start) begin
            r_gx <= ((r_n == '0) || (r_d == '0)) ? PW'(1) : r_n;
            r_gy <= ((r_n == '0) || (r_d == '0)) ? PW'(1) : r_d;
            r_gk <= '0;
        end else if (i_cmd.gcd_step && (r_gx != r_gy)) begin
            if (!r_gx[0] && !r_gy[0]) begin
                r_gx <= gx_sh;
                r_gy <= gy_sh;
                r_gk <= r_gk + CW'(1);
            end else if (!r_gx[0]) begin
                r_gx <= gx_sh;
            end else if (!r_gy[0]) begin
                r_gy <= gy_sh;
            end else if (r_gx > r_gy) begin
                r_gx <= (r_gx - r_gy) >> 1;
            end else begin
                r_gy <= (r_gy - r_gx) >> 1;
            end
        end
    end

    // two restoring dividers sharing one divisor, one quotient bit a cycle
    always_comb begin
        tr0 = {r_rem0, r_q0[PW-1]} - {1'b0, r_g};
        tr1 = {r_rem1, r_q1[PW-1]} - {1'b0, r_g};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_div_busy <= 1'b1;
            r_cnt <= CW'(PW);
        end else if (i_cmd.div_step && r_div_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) r_div_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_g <= g_full;
            r_q0 <= r_n;
            r_q1 <= r_d;
            r_rem0 <= '0;
            r_rem1 <= '0;
        end else if (i_cmd.div_step && r_div_busy) begin
            if (!tr0[PW]) begin
                r_rem0 <= tr0[PW-1:0];
                r_q0 <= {r_q0[PW-2:0], 1'b1};
            end else begin
                r_rem0 <= {r_rem0[PW-2:0], r_q0[PW-1]};
                r_q0 <= {r_q0[PW-2:0], 1'b0};
            end
            if (!tr1[PW]) begin
                r_rem1 <= tr1[PW-1:0];
                r_q1 <= {r_q1[PW-2:0], 1'b1};
            end else begin
                r_rem1 <= {r_rem1[PW-2:0], r_q1[PW-1]};
                r_q1 <= {r_q1[PW-2:0], 1'b0};
            end
        end
    end

    // result selection
    always_comb begin
        num_wide = r_q0;
        den_wide = r_q1;
        unique case (r_mode)
            MODE_SUM: begin
                num_wide = r_q0;
                den_wide = r_q1;
            end
            MODE_EMPTY: begin
                num_wide = '0;
                den_wide = '0;
            end
            default: begin
                num_wide = PW'($signed(r_an));
                den_wide = PW'($signed(r_ad));
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_sum_num <= SUM_NUM_W'($signed({(PW > SUM_NUM_W) ? 1'b0 : num_wide[PW-1],
                                              num_wide}));
            r_sum_den <= SUM_DEN_W'($signed({(PW > SUM_DEN_W) ? 1'b0 : den_wide[PW-1],
                                              den_wide}));
        end
    end

    assign o_sts.gcd_done = (r_gx == r_gy);
    assign o_sts.div_done = !r_div_busy;
    assign o_sum_num      = r_sum_num;
    assign o_sum_den      = r_sum_den;
    assign o_empty_flag   = (r_sum_num == '0) && (r_sum_den == '0);

endmodule

FILE: sv/far_ctrl.sv
// controller: sequences load, multiply, gcd, divide and output transfer
`timescale 1ns / 1ps
module far_ctrl
    import far_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_first;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= (n_state != r_state);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_MUL;
            ST_MUL:  n_state = ST_GCD;
            ST_GCD:  if (!r_first && i_sts.gcd_done) n_state = ST_DIV;
            ST_DIV:  if (!r_first && i_sts.div_done) n_state = ST_OUT;
            ST_OUT:  if (i_out_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MUL: o_cmd.mul = 1'b1;
            ST_GCD: begin
                o_cmd.gcd_start = r_first;
                o_cmd.gcd_step = !r_first;
                o_cmd.div_start = !r_first && i_sts.gcd_done;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.out_load = !r_first && i_sts.div_done;
            end
            ST_OUT: o_out_valid = 1'b1;
            default: o_cmd = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("input taken while result pending");
    a_single_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.load, o_cmd.mul, o_cmd.gcd_step, o_cmd.div_step}) <= 1)
        else $error("overlapping commands");
`endif

endmodule

FILE: test/far_checker.sv
// checker for the fraction add and reduce block: predicts each result and compares it
`timescale 1ns / 1ps
module far_checker
    import far_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
    parameter int IN_W = ((4*OPERAND_WIDTH+7)/8)*8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  logic [IN_W-1:0] i_in_data,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  logic [63:0]     i_out_data,
    output int              o_fail_count,
    output int              o_pending
);

    typedef struct packed {
        logic [SUM_NUM_W-1:0] num;
        logic [SUM_DEN_W-1:0] den;
        logic                 empty;
    } t_frac_sum;

    t_frac_sum sums_due[$];
    int fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = sums_due.size();

    function automatic longint sext_operand(logic [OPERAND_WIDTH-1:0] v);
        longint r;
        r = longint'(v);
        if (v[OPERAND_WIDTH-1])
            r = r - (longint'(1) << OPERAND_WIDTH);
        return r;
    endfunction

    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // cross multiply and reduce, or handle the empty and pass-through cases
    function automatic t_frac_sum add_reduce(logic [IN_W-1:0] d);
        longint an, ad, bn, bd;
        longint unsigned n, dd, g;
        t_frac_sum s;
        an = sext_operand(d[0*OPERAND_WIDTH +: OPERAND_WIDTH]);
        ad = sext_operand(d[1*OPERAND_WIDTH +: OPERAND_WIDTH]);
        bn = sext_operand(d[2*OPERAND_WIDTH +: OPERAND_WIDTH]);
        bd = sext_operand(d[3*OPERAND_WIDTH +: OPERAND_WIDTH]);
        if (an >= 0 && ad > 0 && bn >= 0 && bd > 0) begin
            n  = an * bd + bn * ad;
            dd = ad * bd;
            g  = (n != 0) ? gcd_of(n, dd) : 1;
            n  = n / g;
            dd = dd / g;
        end else if ((an == 0 && ad == 0) || (bn == 0 && bd == 0)) begin
            n  = 0;
            dd = 0;
        end else begin
            n  = an;
            dd = ad;
        end
        s.num   = n[SUM_NUM_W-1:0];
        s.den   = dd[SUM_DEN_W-1:0];
        s.empty = (s.num == 0 && s.den == 0);
        return s;
    endfunction

    // watch both channels at the rising edge
    always @(posedge i_clk) begin
        t_frac_sum want, got;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                sums_due.push_back(add_reduce(i_in_data));
            if (i_out_valid && i_out_ready) begin
                got.num   = i_out_data[SUM_NUM_W-1:0];
                got.den   = i_out_data[SUM_NUM_W +: SUM_DEN_W];
                got.empty = i_out_data[SUM_NUM_W+SUM_DEN_W];
                if (sums_due.size() == 0) begin
                    $error("unexpected result transfer %h", i_out_data);
                    fails++;
                end else begin
                    want = sums_due.pop_front();
                    if (got.num !== want.num) begin
                        $error("sum_num expected %0d got %0d", want.num, got.num);
                        fails++;
                    end
                    if (got.den !== want.den) begin
                        $error("sum_den expected %0d got %0d", want.den, got.den);
                        fails++;
                    end
                    if (got.empty !== want.empty) begin
                        $error("empty_flag expected %0d got %0d", want.empty, got.empty);
                        fails++;
                    end
                end
            end
        end
    end

endmodule

FILE: test/tb_top.sv
// testbench top for the fraction add and reduce block: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_top;
    import far_pkg::*;

    localparam int OW   = OPERAND_WIDTH_DEF;
    localparam int IN_W = ((4*OW+7)/8)*8;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [63:0]     m_axis_tdata;
    int              fail_count, pending;
    int              send_idle_pct = 0, recv_idle_pct = 0;
    int              n_sent = 0;

    fraction_add_reduce #(.OPERAND_WIDTH(OW)) dut (.*);

    far_checker #(.OPERAND_WIDTH(OW)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .i_out_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #50ms;
        $display("timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver stall at random
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // one transfer on the input channel, with a random gap first;
    // tvalid stays high after the transfer unless a gap follows
    task automatic send_fractions(logic [OW-1:0] an, ad, bn, bd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({bd, bn, ad, an});
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        n_sent++;
    endtask

    function automatic logic [OW-1:0] pick_value(int kind);
        unique case (kind)
            0: return '0;
            1: return OW'(1);
            2: return {1'b0, {(OW-1){1'b1}}};
            3: return {1'b1, {(OW-1){1'b0}}};
            4: return '1;
            5: return OW'($urandom_range(12));
            6: return OW'($urandom_range(255));
            default: return OW'($urandom);
        endcase
    endfunction

    // mostly valid fractions, some negative or empty ones
    task automatic random_item();
        logic [OW-1:0] v[4];
        int mode;
        mode = $urandom_range(99);
        for (int k = 0; k < 4; k++) begin
            v[k] = pick_value($urandom_range(7));
            if (mode < 75)
                v[k][OW-1] = 1'b0;
            if (mode < 75 && k % 2 == 1 && v[k] == '0)
                v[k] = OW'(1);
        end
        if (mode >= 90) begin
            v[2] = '0;
            v[3] = '0;
        end
        send_fractions(v[0], v[1], v[2], v[3]);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, zero sum, empty operands, pass through
        send_fractions(1, 2, 1, 3);
        send_fractions(1, 2, 1, 2);
        send_fractions(0, 5, 0, 7);
        send_fractions(16'h7FFF, 1, 16'h7FFF, 1);
        send_fractions(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_fractions(1, 16'h7FFF, 1, 16'h7FFE);
        send_fractions(0, 0, 3, 4);
        send_fractions(3, 4, 0, 0);
        send_fractions(0, 0, 0, 0);
        send_fractions(16'hFFFF, 3, 0, 0);
        send_fractions(16'h8000, 16'h8000, 1, 2);
        send_fractions(5, 16'hFFFD, 1, 2);
        send_fractions(1, 0, 1, 2);
        send_fractions(1, 2, 16'hFFFF, 2);
        send_fractions(1, 2, 1, 0);
        send_fractions(6, 4, 10, 8);
        send_fractions(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
        // random, three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 77 : 0;
            recv_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 30 : 0;
            repeat (150) random_item();
        end
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d fraction pairs: valid sums, zero sums, empty and invalid operands",
                 n_sent);
        $display("sender and receiver idling in three phases, limits of the 16-bit range");
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: fraction_add_reduce.f
sv/far_pkg.sv
sv/far_datapath.sv
sv/far_ctrl.sv
sv/fraction_add_reduce.sv
test/far_checker.sv
test/tb_top.sv
